// ===== src/crf_pkg.sv =====
// crf_pkg: widths, command and status types, angle table and helper functions
// for the complementary roll filter. No dependencies; imported by every module
// and referenced by the channel interfaces.
`timescale 1ns / 1ps

package crf_pkg;

  localparam int CORDIC_ITERATIONS = 20;
  localparam int CNT_W             = $clog2(CORDIC_ITERATIONS);

  localparam int GYRO_W   = 24;
  localparam int ACCEL_W  = 16;
  localparam int ROLL_W   = 32;
  localparam int ACC_W    = 25;
  localparam int WEIGHT_W = 17;
  localparam int PERIOD_W = 21;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  localparam int PRESCALE = 14;
  localparam int XY_W     = 33;
  localparam int Z_W      = 27;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 22;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int STEP_W   = 34;
  localparam int EST_SUM_W = 35;
  localparam int MIX_W    = 50;
  localparam int SAT_IN_W = 51;
  localparam int STEP_FRAC_SHIFT = 12;
  localparam int MIX_FRAC_SHIFT  = 16;

  localparam logic [WEIGHT_W-1:0] ONE_Q16            = 17'd65536;
  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RESET = 17'd64225;
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 21'd1049;

  localparam logic signed [Z_W-1:0]    HALF_TURN = 27'sd11796480;
  localparam logic signed [ACC_W-1:0]  ACC_LIMIT = 25'sd11796480;
  localparam logic signed [ROLL_W-1:0] ROLL_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [ROLL_W-1:0] ROLL_MIN  = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_WEIGHT  = 1'b0,
    REG_SAMPLE_PERIOD = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             load;
    logic             cordic_step;
    logic [CNT_W-1:0] iter;
    logic             step_mul;
    logic             step_calc;
    logic             step_add;
    logic             mix_a;
    logic             mix_b;
    logic             writeback;
  } crf_cmd_t;

  typedef struct packed {
    logic out_free;
  } crf_status_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = 27'sd2949120;
      5'd1:    a = 27'sd1740967;
      5'd2:    a = 27'sd919879;
      5'd3:    a = 27'sd466945;
      5'd4:    a = 27'sd234379;
      5'd5:    a = 27'sd117304;
      5'd6:    a = 27'sd58666;
      5'd7:    a = 27'sd29335;
      5'd8:    a = 27'sd14668;
      5'd9:    a = 27'sd7334;
      5'd10:   a = 27'sd3667;
      5'd11:   a = 27'sd1833;
      5'd12:   a = 27'sd917;
      5'd13:   a = 27'sd458;
      5'd14:   a = 27'sd229;
      5'd15:   a = 27'sd115;
      5'd16:   a = 27'sd57;
      5'd17:   a = 27'sd29;
      5'd18:   a = 27'sd14;
      5'd19:   a = 27'sd7;
      5'd20:   a = 27'sd4;
      5'd21:   a = 27'sd2;
      5'd22:   a = 27'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [ROLL_W-1:0] sat_roll(input logic signed [SAT_IN_W-1:0] v);
    logic signed [ROLL_W-1:0] r;
    if (v > SAT_IN_W'(ROLL_MAX)) begin
      r = ROLL_MAX;
    end else if (v < SAT_IN_W'(ROLL_MIN)) begin
      r = ROLL_MIN;
    end else begin
      r = ROLL_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/crf_intf.sv =====
// crf channel interfaces: imu sample input, roll result output, register write.
// Depends on crf_pkg for field widths.
`timescale 1ns / 1ps

interface crf_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [crf_pkg::GYRO_W-1:0]     gyro_z_rate;
  logic signed [crf_pkg::ACCEL_W-1:0]    accel_x;
  logic signed [crf_pkg::ACCEL_W-1:0]    accel_y;

  modport source (output valid, gyro_z_rate, accel_x, accel_y, input ready);
  modport sink   (input valid, gyro_z_rate, accel_x, accel_y, output ready);
endinterface

interface crf_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [crf_pkg::ROLL_W-1:0]     roll_integrated;
  logic signed [crf_pkg::ACC_W-1:0]      roll_from_accel;
  logic signed [crf_pkg::ROLL_W-1:0]     roll_blended;

  modport source (output valid, roll_integrated, roll_from_accel, roll_blended, input ready);
  modport sink   (input valid, roll_integrated, roll_from_accel, roll_blended, output ready);
endinterface

interface crf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [crf_pkg::CFG_IDX_W-1:0]         index;
  logic [crf_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/crf_ctrl.sv =====
// crf_ctrl: sequencer for one sample: load, cordic micro-rotations with the
// gyro step alongside, two blend multiplies, writeback. Depends on crf_pkg.
`timescale 1ns / 1ps

module crf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  crf_pkg::crf_status_t status_i,
  output crf_pkg::crf_cmd_t    cmd_o
);
  import crf_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CORDIC,
    MIX_A,
    MIX_B,
    WB
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             in_ready_q;
  logic             accept;

  assign accept     = in_valid_i && in_ready_q;
  assign in_ready_o = in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= IDLE;
      cnt_q      <= '0;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        IDLE: begin
          if (accept) begin
            state_q    <= CORDIC;
            cnt_q      <= '0;
            in_ready_q <= 1'b0;
          end
        end
        CORDIC: begin
          if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
            state_q <= MIX_A;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        MIX_A: begin
          state_q <= MIX_B;
        end
        MIX_B: begin
          state_q <= WB;
        end
        WB: begin
          if (status_i.out_free) begin
            state_q    <= IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = accept;
    cmd_o.cordic_step = (state_q == CORDIC);
    cmd_o.iter        = cnt_q;
    cmd_o.step_mul    = (state_q == CORDIC) && (cnt_q == CNT_W'(0));
    cmd_o.step_calc   = (state_q == CORDIC) && (cnt_q == CNT_W'(1));
    cmd_o.step_add    = (state_q == CORDIC) && (cnt_q == CNT_W'(2));
    cmd_o.mix_a       = (state_q == MIX_A);
    cmd_o.mix_b       = (state_q == MIX_B);
    cmd_o.writeback   = (state_q == WB) && status_i.out_free;
  end

endmodule

// ===== src/crf_datapath.sv =====
// crf_datapath: config registers, vectoring cordic, shared multiplier, roll
// integrators and the result register. Depends on crf_pkg and crf_intf.
`timescale 1ns / 1ps

module crf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  crf_pkg::crf_cmd_t                  cmd_i,
  output crf_pkg::crf_status_t               status_o,
  input  logic signed [crf_pkg::GYRO_W-1:0]  gyro_z_rate_i,
  input  logic signed [crf_pkg::ACCEL_W-1:0] accel_x_i,
  input  logic signed [crf_pkg::ACCEL_W-1:0] accel_y_i,
  crf_cfg_if.sink                            cfg_i,
  crf_result_if.source                       result_o
);
  import crf_pkg::*;

  logic [WEIGHT_W-1:0] blend_weight_q;
  logic [PERIOD_W-1:0] sample_period_q;
  logic [WEIGHT_W-1:0] alpha;

  logic signed [GYRO_W-1:0]  rate_q;
  logic signed [XY_W-1:0]    x_q, y_q;
  logic signed [Z_W-1:0]     z_q;
  logic                      zero_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [STEP_W-1:0]  step_q;
  logic signed [ROLL_W-1:0]  gyro_q, blend_q, pred_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [MIX_W-1:0]   mix_q;

  logic signed [ROLL_W-1:0]  res_gyro_q, res_blend_q;
  logic signed [ACC_W-1:0]   res_acc_q;
  logic                      out_valid_q;

  logic signed [ACCEL_W:0]   ax_e, ay_e, x0, y0;
  logic signed [Z_W-1:0]     z0;
  logic signed [ACCEL_W+PRESCALE:0] x0_s, y0_s;
  logic signed [XY_W-1:0]    dx, dy;
  logic signed [Z_W-1:0]     ang;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [EST_SUM_W-1:0] gyro_sum, pred_sum;
  logic signed [SAT_IN_W-1:0]  mix_sum;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ROLL_W-1:0]  blend_d;

  assign cfg_i.ready = 1'b1;
  assign alpha = (blend_weight_q > ONE_Q16) ? ONE_Q16 : blend_weight_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_weight_q  <= BLEND_WEIGHT_RESET;
      sample_period_q <= SAMPLE_PERIOD_RESET;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_BLEND_WEIGHT:  blend_weight_q  <= cfg_i.data[WEIGHT_W-1:0];
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_i.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // pre-rotation into the right half plane
  always_comb begin
    ax_e = (ACCEL_W+1)'(accel_x_i);
    ay_e = (ACCEL_W+1)'(accel_y_i);
    if (ay_e < 0) begin
      x0 = -ay_e;
      y0 = -ax_e;
      z0 = (ax_e < 0) ? -HALF_TURN : HALF_TURN;
    end else begin
      x0 = ay_e;
      y0 = ax_e;
      z0 = '0;
    end
    x0_s = {x0, PRESCALE'(0)};
    y0_s = {y0, PRESCALE'(0)};
  end

  assign dx  = y_q >>> cmd_i.iter;
  assign dy  = x_q >>> cmd_i.iter;
  assign ang = atan_deg(5'(cmd_i.iter));

  // cordic
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rate_q <= gyro_z_rate_i;
      x_q    <= XY_W'(x0_s);
      y_q    <= XY_W'(y0_s);
      z_q    <= z0;
      zero_q <= (accel_x_i == '0) && (accel_y_i == '0);
    end else if (cmd_i.cordic_step) begin
      if (!y_q[XY_W-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.step_mul) begin
      mul_a = MUL_A_W'(rate_q);
      mul_b = MUL_B_W'($signed({1'b0, sample_period_q}));
    end else if (cmd_i.mix_a) begin
      mul_a = MUL_A_W'(pred_q);
      mul_b = MUL_B_W'($signed({1'b0, alpha}));
    end else if (cmd_i.mix_b) begin
      mul_a = MUL_A_W'(acc_q);
      mul_b = MUL_B_W'($signed({1'b0, ONE_Q16 - alpha}));
    end
  end

  always_comb begin
    if (zero_q) begin
      acc_d = '0;
    end else if (z_q > HALF_TURN) begin
      acc_d = ACC_LIMIT;
    end else if (z_q < -HALF_TURN) begin
      acc_d = -ACC_LIMIT;
    end else begin
      acc_d = ACC_W'(z_q);
    end
  end

  assign gyro_sum = EST_SUM_W'(gyro_q) + EST_SUM_W'(step_q);
  assign pred_sum = EST_SUM_W'(blend_q) + EST_SUM_W'(step_q);
  assign mix_sum  = SAT_IN_W'(mix_q) + SAT_IN_W'(prod_q);
  assign blend_d  = sat_roll(mix_sum >>> MIX_FRAC_SHIFT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_mul || cmd_i.mix_a || cmd_i.mix_b) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.step_calc) begin
      step_q <= STEP_W'((prod_q + PROD_W'(2048)) >>> STEP_FRAC_SHIFT);
    end
    if (cmd_i.step_add) begin
      pred_q <= sat_roll(SAT_IN_W'(pred_sum));
    end
    if (cmd_i.mix_a) begin
      acc_q <= acc_d;
    end
    if (cmd_i.mix_b) begin
      mix_q <= MIX_W'(prod_q) + MIX_W'(32768);
    end
    if (cmd_i.writeback) begin
      res_gyro_q  <= gyro_q;
      res_acc_q   <= acc_q;
      res_blend_q <= blend_d;
    end
  end

  // roll state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_q      <= '0;
      blend_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step_add) begin
        gyro_q <= sat_roll(SAT_IN_W'(gyro_sum));
      end
      if (cmd_i.writeback) begin
        blend_q     <= blend_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || result_o.ready;

  assign result_o.valid           = out_valid_q;
  assign result_o.roll_integrated = res_gyro_q;
  assign result_o.roll_from_accel = res_acc_q;
  assign result_o.roll_blended    = res_blend_q;

endmodule

// ===== src/complementary_roll_filter.sv =====
// complementary_roll_filter: top level joining crf_ctrl and crf_datapath.
// Depends on crf_pkg, crf_intf, crf_ctrl and crf_datapath.
`timescale 1ns / 1ps

// Complementary roll filter. Each sample transfer (gyro z rate, accel x and
// y) yields one result transfer: integrated gyro roll and blended roll in
// degrees Q15.16, accelerometer roll atan2(accel_x, accel_y) in degrees Q8.16.
// A sample runs through a load, one cordic micro-rotation per cycle, the two
// blend multiplies on the shared multiplier (MIX_A, MIX_B) and a writeback that
// waits until the result register is free; the gyro step uses
// the same multiplier while the cordic runs. A new sample is accepted as soon
// as the previous one is in the result register, even if that result has not
// yet been taken. Register writes are accepted at any time with ready high
// and should be issued only while the filter is idle.
module complementary_roll_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  crf_sample_if.sink   sample_i,
  crf_result_if.source result_o,
  crf_cfg_if.sink      cfg_i
);
  import crf_pkg::*;

  crf_cmd_t    cmd;
  crf_status_t status;
  logic        in_ready;

  assign sample_i.ready = in_ready;

  crf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .gyro_z_rate_i (sample_i.gyro_z_rate),
    .accel_x_i     (sample_i.accel_x),
    .accel_y_i     (sample_i.accel_y),
    .cfg_i         (cfg_i),
    .result_o      (result_o)
  );

endmodule

// ===== test/crf_roll_checker.sv =====
// crf_roll_checker: watches the sample, result and register channels of the
// complementary roll filter, predicts every roll result and compares it.
// Depends on crf_pkg and the crf channel interfaces.
`timescale 1ns / 1ps

module crf_roll_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  crf_sample_if sample_mon,
  crf_result_if result_mon,
  crf_cfg_if    cfg_mon,
  output int    fail_count_o,
  output int    outstanding_o
);
  import crf_pkg::*;

  // atan(2^-i) in degrees, Q.16
  localparam longint ATAN_DEG_Q16 [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [ROLL_W-1:0] integrated;
    logic signed [ACC_W-1:0]  from_accel;
    logic signed [ROLL_W-1:0] blended;
  } roll_triplet_t;

  roll_triplet_t       pending_rolls[$];
  logic [WEIGHT_W-1:0] blend_weight  = BLEND_WEIGHT_RESET;
  logic [PERIOD_W-1:0] sample_period = SAMPLE_PERIOD_RESET;
  longint              gyro_roll     = 0;
  longint              blended_roll  = 0;
  int                  mismatches    = 0;
  int                  outstanding   = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(input string what);
    $display("[%0t] roll check: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_angle(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic longint clamp_roll(input longint v);
    if (v > longint'(ROLL_MAX)) begin
      return longint'(ROLL_MAX);
    end
    if (v < longint'(ROLL_MIN)) begin
      return longint'(ROLL_MIN);
    end
    return v;
  endfunction

  // vectoring cordic, atan2(ax, ay) in degrees Q.16
  function automatic longint accel_roll_deg(input longint ax, input longint ay);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint a;
    int     s;
    x = ay;
    y = ax;
    z = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
      x = -x;
      y = -y;
    end
    x = x <<< PRESCALE;
    y = y <<< PRESCALE;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      s  = (i < 32) ? i : 31;
      a  = (i < 32) ? ATAN_DEG_Q16[i] : 0;
      dx = y >>> s;
      dy = x >>> s;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += a;
      end else begin
        x -= dx;
        y += dy;
        z -= a;
      end
    end
    if (z > longint'(ACC_LIMIT)) begin
      z = longint'(ACC_LIMIT);
    end
    if (z < -longint'(ACC_LIMIT)) begin
      z = -longint'(ACC_LIMIT);
    end
    return z;
  endfunction

  function automatic roll_triplet_t advance_roll(input longint rate, input longint ax,
                                                 input longint ay);
    longint        step;
    longint        alpha;
    longint        acc;
    longint        pred;
    longint        mix;
    roll_triplet_t r;
    step  = (rate * longint'(sample_period) + (longint'(1) <<< (STEP_FRAC_SHIFT - 1)))
            >>> STEP_FRAC_SHIFT;
    alpha = (blend_weight > ONE_Q16) ? longint'(ONE_Q16) : longint'(blend_weight);
    acc   = accel_roll_deg(ax, ay);
    gyro_roll    = clamp_roll(gyro_roll + step);
    pred         = clamp_roll(blended_roll + step);
    mix          = alpha * pred + (longint'(ONE_Q16) - alpha) * acc
                   + (longint'(1) <<< (MIX_FRAC_SHIFT - 1));
    blended_roll = clamp_roll(mix >>> MIX_FRAC_SHIFT);
    r.integrated = ROLL_W'(gyro_roll);
    r.from_accel = ACC_W'(acc);
    r.blended    = ROLL_W'(blended_roll);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    roll_triplet_t want;
    if (!rst_ni) begin
      pending_rolls.delete();
      gyro_roll     = 0;
      blended_roll  = 0;
      blend_weight  = BLEND_WEIGHT_RESET;
      sample_period = SAMPLE_PERIOD_RESET;
      outstanding   = 0;
    end else begin
      if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1) begin
        if (pending_rolls.size() == 0) begin
          report_mismatch($sformatf("unexpected result gyro %0d accel %0d blended %0d",
                                    result_mon.roll_integrated, result_mon.roll_from_accel,
                                    result_mon.roll_blended));
        end else begin
          want = pending_rolls.pop_front();
          check_angle("roll_integrated", result_mon.roll_integrated, want.integrated);
          check_angle("roll_from_accel", result_mon.roll_from_accel, want.from_accel);
          check_angle("roll_blended", result_mon.roll_blended, want.blended);
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          REG_BLEND_WEIGHT:  blend_weight  = cfg_mon.data[WEIGHT_W-1:0];
          REG_SAMPLE_PERIOD: sample_period = cfg_mon.data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (sample_mon.valid === 1'b1 && sample_mon.ready === 1'b1) begin
        pending_rolls.push_back(advance_roll(sample_mon.gyro_z_rate, sample_mon.accel_x,
                                             sample_mon.accel_y));
      end
      outstanding = pending_rolls.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// tb_top: drives imu samples and register writes into complementary_roll_filter
// with random gaps and result stalls, and reports the verdict.
// Depends on crf_pkg, crf_intf, the filter rtl and crf_roll_checker.
`timescale 1ns / 1ps

module tb_top;
  import crf_pkg::*;

  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint RUN_LIMIT_NS = 5_000_000;

  localparam logic signed [GYRO_W-1:0]  RATE_MAX  = 24'sh7F_FFFF;
  localparam logic signed [GYRO_W-1:0]  RATE_MIN  = 24'sh80_0000;
  localparam logic signed [ACCEL_W-1:0] ACCEL_MAX = 16'sh7FFF;
  localparam logic signed [ACCEL_W-1:0] ACCEL_MIN = 16'sh8000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sender_quiet = 0;
  bit   long_hold_req = 1'b0;

  crf_sample_if sample_ch ();
  crf_result_if result_ch ();
  crf_cfg_if    cfg_ch ();

  complementary_roll_filter dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  crf_roll_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .sample_mon    (sample_ch),
    .result_mon    (result_ch),
    .cfg_mon       (cfg_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [GYRO_W-1:0] pick_rate();
    logic signed [GYRO_W-1:0] v;
    v = GYRO_W'($urandom);
    case ($urandom_range(0, 7))
      0: v = RATE_MIN;
      1: v = RATE_MAX;
      2: v = '0;
      3: v = GYRO_W'(int'($urandom_range(0, 8191)) - 4096);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [ACCEL_W-1:0] pick_accel();
    logic signed [ACCEL_W-1:0] v;
    v = ACCEL_W'($urandom);
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = ACCEL_MIN;
      2: v = ACCEL_MAX;
      3: v = ACCEL_W'(int'($urandom_range(0, 16)) - 8);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic signed [GYRO_W-1:0] rate,
                             input logic signed [ACCEL_W-1:0] ax,
                             input logic signed [ACCEL_W-1:0] ay);
    int gap;
    if (sender_quiet > 0) begin
      gap = 0;
      sender_quiet--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) begin
        sender_quiet = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.gyro_z_rate <= rate;
    sample_ch.accel_x     <= ax;
    sample_ch.accel_y     <= ay;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [WEIGHT_W-1:0] weight,
                                input logic [PERIOD_W-1:0] period);
    wait_idle();
    for (int r = 0; r < 2; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= (r == 0) ? REG_BLEND_WEIGHT : REG_SAMPLE_PERIOD;
      cfg_ch.data  <= (r == 0) ? CFG_DATA_W'(weight) : CFG_DATA_W'(period);
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [WEIGHT_W-1:0] weight,
                           input logic [PERIOD_W-1:0] period,
                           input int count, input bit with_hold);
    apply_settings(weight, period);
    if (with_hold) begin
      long_hold_req = 1'b1;
      sender_quiet  = 60;
    end
    repeat (count) send_sample(pick_rate(), pick_accel(), pick_accel());
  endtask

  // result side: random stalls, quiet runs and one long hold per request
  initial begin : result_sink
    int gap;
    int quiet;
    int held;
    quiet = 0;
    result_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        result_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        long_hold_req = 1'b0;
      end else begin
        if (quiet > 0) begin
          gap = 0;
          quiet--;
        end else begin
          gap = $urandom_range(0, 10);
          if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
          end
        end
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    rst_n                 = 1'b0;
    sample_ch.valid       <= 1'b0;
    sample_ch.gyro_z_rate <= '0;
    sample_ch.accel_x     <= '0;
    sample_ch.accel_y     <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_BLEND_WEIGHT;
    cfg_ch.data           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples under reset settings
    send_sample('0, '0, '0);
    send_sample(RATE_MAX, 16'sd0, 16'sd1);
    send_sample(RATE_MAX, 16'sd1, 16'sd0);
    send_sample(RATE_MIN, -16'sd1, 16'sd0);
    send_sample(RATE_MIN, 16'sd0, -16'sd1);
    send_sample('0, 16'sd1, -16'sd1);
    send_sample('0, -16'sd1, -16'sd1);
    send_sample(24'sd256, ACCEL_MAX, ACCEL_MAX);
    send_sample(-24'sd256, ACCEL_MIN, ACCEL_MIN);
    send_sample(24'sd1, ACCEL_MAX, ACCEL_MIN);
    send_sample(-24'sd1, ACCEL_MIN, ACCEL_MAX);
    send_sample(RATE_MAX, ACCEL_MIN, '0);
    send_sample(RATE_MAX, ACCEL_MAX, '0);
    send_sample(RATE_MIN, '0, ACCEL_MAX);
    send_sample(RATE_MIN, '0, ACCEL_MIN);
    send_sample(24'sh55_5555, 16'sh5555, 16'shAAAA);
    send_sample(24'shAA_AAAA, 16'shAAAA, 16'sh5555);
    send_sample('0, '0, '0);

    run_phase(17'd0, 21'd0, 100, 1'b0);
    run_phase(ONE_Q16, 21'd1048576, 120, 1'b0);
    run_phase(17'd131071, 21'd2097151, 100, 1'b1);
    run_phase(17'd32768, SAMPLE_PERIOD_RESET, 160, 1'b1);
    run_phase(WEIGHT_W'($urandom_range(0, 131071)), PERIOD_W'($urandom_range(0, 2097151)),
              160, 1'b0);
    run_phase(BLEND_WEIGHT_RESET, PERIOD_W'($urandom_range(1, 4096)), 160, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
